@@ design/four_voice_sample_player_pwm_core_defines.svh @@
// Assertion macros of the sample player design, used by fvsp_back.
// No dependencies; include this file by its bare name.
`ifndef FOUR_VOICE_SAMPLE_PLAYER_PWM_CORE_DEFINES_SVH
`define FOUR_VOICE_SAMPLE_PLAYER_PWM_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FVSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FVSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/fvsp_pkg.sv @@
// Shared types and constants of the four-voice sample player.
// No dependencies.
package fvsp_pkg;

    localparam int NUM_VOICES       = 4;
    localparam int VOICE_BITS       = $clog2(NUM_VOICES);
    localparam int SAMPLE_ADDR_BITS = 16;
    localparam int PWM_BITS         = 6;
    localparam int QUEUE_DEPTH      = 2;
    localparam int STEP_BITS        = $clog2(NUM_VOICES + 1);

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_TRIGGER = 2'd2,
        REQ_SET     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TICK,
        BK_HOLD
    } t_back_state;

    // One classified command; trigger and set fields are already clamped.
    typedef struct packed {
        t_req                    req_type;
        logic [VOICE_BITS-1:0]   voice;
        logic [15:0]             mem_addr;
        logic signed [7:0]       mem_data;
        logic [15:0]             len;
        logic [15:0]             loop;
        logic [15:0]             pos;
        logic [15:0]             period;
        logic [6:0]              volume;
    } t_cmd;

endpackage

@@ design/fvsp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fvsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/fvsp_front.sv @@
// Front end: accepts request items, clamps trigger and set fields and
// queues the resulting commands. Depends on fvsp_pkg.
module fvsp_front
    import fvsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic [VOICE_BITS-1:0] i_voice,
    input  logic [15:0]           i_mem_addr,
    input  logic signed [7:0]     i_mem_data,
    input  logic [15:0]           i_sample_len,
    input  logic [15:0]           i_loop_len,
    input  logic [15:0]           i_start_offset,
    input  logic [15:0]           i_period,
    input  logic [6:0]            i_volume,
    output logic                  o_cmd_valid,
    output t_cmd                  o_cmd,
    input  logic                  i_cmd_pop
);

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              cmd;
    logic [15:0]       len_c;
    logic [15:0]       loop_c;
    logic [15:0]       len_m1;
    logic              push;
    logic              pop;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_comb begin
        len_c  = (i_sample_len == 16'd0) ? 16'd1 : i_sample_len;
        loop_c = (i_loop_len == 16'd0) ? 16'd1 : i_loop_len;
        if (loop_c > len_c) begin
            loop_c = len_c;
        end
        len_m1 = len_c - 16'd1;

        cmd.req_type = t_req'(i_req_type);
        cmd.voice    = i_voice;
        cmd.mem_addr = i_mem_addr;
        cmd.mem_data = i_mem_data;
        cmd.len      = len_c;
        cmd.loop     = loop_c;
        cmd.pos      = (i_start_offset > len_m1) ? len_m1 : i_start_offset;
        cmd.period   = (i_period == 16'd0) ? 16'd1 : i_period;
        cmd.volume   = i_volume;
    end

    assign o_in_ready  = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/fvsp_back.sv @@
// Back end: executes queued commands, owns the voice state and the sample
// memory, and mixes one stereo result per tick. Depends on fvsp_pkg and fvsp_ram.
`include "four_voice_sample_player_pwm_core_defines.svh"

module fvsp_back
    import fvsp_pkg::*;
#(
    parameter int ADDR_BITS = SAMPLE_ADDR_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic signed [8:0] o_left_sum,
    output logic signed [8:0] o_right_sum
);

    localparam int SUM_W = (ADDR_BITS > 17) ? ADDR_BITS : 17;
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(NUM_VOICES);

    t_back_state           r_state, n_state;
    logic [STEP_BITS-1:0]  r_step, n_step;

    logic                  r_active [NUM_VOICES];
    logic [15:0]           r_base   [NUM_VOICES];
    logic [15:0]           r_pos    [NUM_VOICES];
    logic [15:0]           r_len    [NUM_VOICES];
    logic [15:0]           r_loop   [NUM_VOICES];
    logic [15:0]           r_period [NUM_VOICES];
    logic [6:0]            r_volume [NUM_VOICES];
    logic [15:0]           r_div    [NUM_VOICES];
    logic [PWM_BITS-1:0]   r_pwm    [NUM_VOICES];
    logic [7:0]            r_cur    [NUM_VOICES];

    logic                  r_fetch;
    logic                  r_gate;
    logic signed [8:0]     r_acc_l;
    logic signed [8:0]     r_acc_r;
    logic                  r_out_valid;
    logic signed [8:0]     r_out_l;
    logic signed [8:0]     r_out_r;

    logic                  dispatch;
    logic                  start_tick;
    logic                  issue_en;
    logic [VOICE_BITS-1:0] issue_v;
    logic                  fetch;
    logic                  gate;
    logic [16:0]           pos_inc;
    logic [15:0]           n_pos;
    logic [15:0]           n_div;
    logic [PWM_BITS-1:0]   n_pwm;
    logic [SUM_W-1:0]      addr_sum;
    logic [SUM_W-1:0]      wr_ext;
    logic                  wr_en;
    logic                  rd_en;
    logic [7:0]            rd_data;

    logic                  acc_en;
    logic [VOICE_BITS-1:0] prev_v;
    logic signed [7:0]     sample;
    logic signed [8:0]     contrib;
    logic signed [8:0]     sum_l;
    logic signed [8:0]     sum_r;
    logic                  out_free;
    logic                  load_out;
    logic signed [8:0]     load_l;
    logic signed [8:0]     load_r;

    assign dispatch   = (r_state == BK_IDLE) && i_cmd_valid;
    assign start_tick = dispatch && (i_cmd.req_type == REQ_TICK);
    assign out_free   = !r_out_valid || i_out_ready;

    // Voice 0 is issued in the dispatch cycle, the rest on steps 1 to 3.
    assign issue_en = start_tick || ((r_state == BK_TICK) && (r_step != STEP_LAST));
    assign issue_v  = (r_state == BK_IDLE) ? '0 : r_step[VOICE_BITS-1:0];

    always_comb begin
        fetch    = r_active[issue_v] && (r_div[issue_v] == 16'd0);
        gate     = r_active[issue_v] && ({1'b0, r_pwm[issue_v]} < r_volume[issue_v]);
        pos_inc  = {1'b0, r_pos[issue_v]} + 17'd1;
        n_pos    = (pos_inc == {1'b0, r_len[issue_v]})
                 ? 16'(pos_inc - {1'b0, r_loop[issue_v]}) : pos_inc[15:0];
        n_div    = fetch ? (r_period[issue_v] - 16'd1) : (r_div[issue_v] - 16'd1);
        n_pwm    = r_pwm[issue_v] + 1'b1;
        addr_sum = SUM_W'(r_base[issue_v]) + SUM_W'(r_pos[issue_v]);
        wr_ext   = SUM_W'(i_cmd.mem_addr);
    end

    assign wr_en = dispatch && (i_cmd.req_type == REQ_WRITE);
    assign rd_en = issue_en && fetch;

    fvsp_ram #(
        .WIDTH (8),
        .DEPTH (1 << ADDR_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_ext[ADDR_BITS-1:0]),
        .i_wr_data (i_cmd.mem_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (addr_sum[ADDR_BITS-1:0]),
        .o_rd_data (rd_data)
    );

    // The voice issued last cycle is mixed now, once its fetched byte is back.
    assign acc_en = (r_state == BK_TICK);
    always_comb begin
        prev_v  = VOICE_BITS'(r_step - 1'b1);
        sample  = r_fetch ? $signed(rd_data) : $signed(r_cur[prev_v]);
        contrib = r_gate ? {sample[7], sample} : 9'sd0;
        sum_l   = r_acc_l;
        sum_r   = r_acc_r;
        if (prev_v[0] == prev_v[1]) begin
            sum_l = r_acc_l + contrib;
        end else begin
            sum_r = r_acc_r + contrib;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        o_cmd_pop = 1'b0;
        load_out  = 1'b0;
        load_l    = sum_l;
        load_r    = sum_r;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.req_type == REQ_TICK) begin
                        n_state = BK_TICK;
                        n_step  = STEP_BITS'(1);
                    end
                end
            end
            BK_TICK: begin
                if (r_step == STEP_LAST) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = BK_IDLE;
                    end else begin
                        n_state = BK_HOLD;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            BK_HOLD: begin
                load_l = r_acc_l;
                load_r = r_acc_r;
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_fetch     <= 1'b0;
            r_gate      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (issue_en) begin
                r_fetch <= fetch;
                r_gate  <= gate;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_tick) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (acc_en) begin
            r_acc_l <= sum_l;
            r_acc_r <= sum_r;
        end
        if (load_out) begin
            r_out_l <= load_l;
            r_out_r <= load_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_active[v] <= 1'b0;
                r_base[v]   <= 16'd0;
                r_pos[v]    <= 16'd0;
                r_len[v]    <= 16'd1;
                r_loop[v]   <= 16'd1;
                r_period[v] <= 16'd1;
                r_volume[v] <= 7'd0;
                r_div[v]    <= 16'd0;
                r_pwm[v]    <= '0;
                r_cur[v]    <= 8'd0;
            end
        end else begin
            if (dispatch && (i_cmd.req_type == REQ_TRIGGER)) begin
                r_active[i_cmd.voice] <= 1'b1;
                r_base[i_cmd.voice]   <= i_cmd.mem_addr;
                r_len[i_cmd.voice]    <= i_cmd.len;
                r_loop[i_cmd.voice]   <= i_cmd.loop;
                r_pos[i_cmd.voice]    <= i_cmd.pos;
            end
            if (dispatch && (i_cmd.req_type == REQ_SET)) begin
                r_period[i_cmd.voice] <= i_cmd.period;
                r_volume[i_cmd.voice] <= i_cmd.volume;
            end
            if (issue_en && r_active[issue_v]) begin
                if (fetch) begin
                    r_pos[issue_v] <= n_pos;
                end
                r_div[issue_v] <= n_div;
                r_pwm[issue_v] <= n_pwm;
            end
            if (acc_en && r_fetch) begin
                r_cur[prev_v] <= rd_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_sum  = r_out_l;
    assign o_right_sum = r_out_r;

    `FVSP_ASSERT_NOW(a_pop_only_idle, i_clk, i_rst_n, o_cmd_pop, r_state == BK_IDLE, "command popped while busy")
    `FVSP_ASSERT_NOW(a_step_range, i_clk, i_rst_n, r_state == BK_TICK, (r_step != '0) && (r_step <= STEP_LAST), "tick step out of range")
    `FVSP_ASSERT_NOW(a_hold_has_result, i_clk, i_rst_n, r_state == BK_HOLD, r_out_valid, "holding a result with the output empty")
    `FVSP_ASSERT_NEXT(a_tick_ends, i_clk, i_rst_n, (r_state == BK_TICK) && (r_step == STEP_LAST), r_state != BK_TICK, "tick did not finish after the last voice")
    `FVSP_ASSERT_NOW(a_no_read_on_write, i_clk, i_rst_n, wr_en, !rd_en, "sample read and write in the same cycle")

endmodule

@@ design/four_voice_sample_player_pwm_core.sv @@
// Four-voice looping sample player with PWM volume gating and stereo mix.
// A tick issues the voices in turn, with at most one memory read per voice on
// the shared read port, then mixes the last voice; other items are executed in
// the cycle they are dispatched. Synchronous active-low reset clears the
// voices, the queue and the output; the sample memory is not cleared and
// holds undefined bytes until written.
module four_voice_sample_player_pwm_core
    import fvsp_pkg::*;
#(
    parameter int SAMPLE_ADDR_BITS_P = SAMPLE_ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic [VOICE_BITS-1:0] i_voice,
    input  logic [15:0]           i_mem_addr,
    input  logic signed [7:0]     i_mem_data,
    input  logic [15:0]           i_sample_len,
    input  logic [15:0]           i_loop_len,
    input  logic [15:0]           i_start_offset,
    input  logic [15:0]           i_period,
    input  logic [6:0]            i_volume,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [8:0]     o_left_sum,
    output logic signed [8:0]     o_right_sum
);

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    fvsp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_voice        (i_voice),
        .i_mem_addr     (i_mem_addr),
        .i_mem_data     (i_mem_data),
        .i_sample_len   (i_sample_len),
        .i_loop_len     (i_loop_len),
        .i_start_offset (i_start_offset),
        .i_period       (i_period),
        .i_volume       (i_volume),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    fvsp_back #(
        .ADDR_BITS (SAMPLE_ADDR_BITS_P)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_left_sum  (o_left_sum),
        .o_right_sum (o_right_sum)
    );

endmodule

@@ tb/tb_four_voice_sample_player_pwm_core.sv @@
// Self-checking testbench of the four-voice sample player core: directed and random items,
// with a scoreboard that predicts each tick's stereo sums from its own voice model.
// Depends on fvsp_pkg and four_voice_sample_player_pwm_core.
`timescale 1ns / 100ps

module tb_four_voice_sample_player_pwm_core;
    import fvsp_pkg::*;

    localparam int TARGET_ITEMS = 1200;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        t_req              kind;
        logic [1:0]        voice;
        logic [15:0]       addr;
        logic [7:0]        data;
        logic [15:0]       len;
        logic [15:0]       loop_len;
        logic [15:0]       offs;
        logic [15:0]       period;
        logic [6:0]        volume;
    } req_item_t;

    typedef struct packed {
        logic signed [8:0] left;
        logic signed [8:0] right;
    } stereo_mix_t;

    class sample_player_scoreboard;
        bit [7:0]  mem     [0:65535];
        bit        written [0:65535];
        bit        active  [4];
        bit [15:0] base    [4];
        bit [15:0] pos     [4];
        bit [15:0] len     [4];
        bit [15:0] lp      [4];
        bit [15:0] per     [4];
        bit [6:0]  vol     [4];
        bit [15:0] div     [4];
        bit [5:0]  pwm     [4];
        bit [7:0]  cur     [4];
        stereo_mix_t expected_mix[$];
        int errors;
        int checked;
        int kind_count[4];

        function new();
            for (int v = 0; v < 4; v++) begin
                active[v] = 0;
                base[v]   = 0;
                pos[v]    = 0;
                len[v]    = 1;
                lp[v]     = 1;
                per[v]    = 1;
                vol[v]    = 0;
                div[v]    = 0;
                pwm[v]    = 0;
                cur[v]    = 0;
            end
            errors  = 0;
            checked = 0;
        endfunction

        function int step_voice(int v);
            bit [16:0] next;
            int level;
            level = 0;
            if (!active[v]) return 0;
            if (div[v] == 0) begin
                cur[v] = mem[base[v] + pos[v]];
                next = {1'b0, pos[v]} + 17'd1;
                if (next == {1'b0, len[v]}) next = next - {1'b0, lp[v]};
                pos[v] = next[15:0];
                div[v] = per[v];
            end
            if ({1'b0, pwm[v]} < vol[v]) level = $signed(cur[v]);
            pwm[v] = pwm[v] + 6'd1;
            div[v] = div[v] - 16'd1;
            return level;
        endfunction

        function void note_input(req_item_t it);
            int left_acc;
            int right_acc;
            bit [15:0] ln;
            bit [15:0] lpn;
            stereo_mix_t mix;
            kind_count[it.kind]++;
            case (it.kind)
                REQ_TICK: begin
                    left_acc  = step_voice(0);
                    right_acc = step_voice(1);
                    right_acc += step_voice(2);
                    left_acc  += step_voice(3);
                    mix.left  = left_acc[8:0];
                    mix.right = right_acc[8:0];
                    expected_mix.push_back(mix);
                end
                REQ_WRITE: begin
                    mem[it.addr]     = it.data;
                    written[it.addr] = 1;
                end
                REQ_TRIGGER: begin
                    ln  = (it.len == 0) ? 16'd1 : it.len;
                    lpn = (it.loop_len == 0) ? 16'd1 : it.loop_len;
                    if (lpn > ln) lpn = ln;
                    active[it.voice] = 1;
                    base[it.voice]   = it.addr;
                    len[it.voice]    = ln;
                    lp[it.voice]     = lpn;
                    pos[it.voice]    = (it.offs > ln - 16'd1) ? ln - 16'd1 : it.offs;
                end
                default: begin
                    per[it.voice] = (it.period == 0) ? 16'd1 : it.period;
                    vol[it.voice] = it.volume;
                end
            endcase
        endfunction

        // Finds a fetch of the next tick that would land on a byte never written.
        function bit unwritten_fetch(output logic [15:0] addr);
            addr = '0;
            for (int v = 0; v < 4; v++) begin
                if (active[v] && div[v] == 0 && !written[base[v] + pos[v]]) begin
                    addr = base[v] + pos[v];
                    return 1;
                end
            end
            return 0;
        endfunction

        function void check_result(logic signed [8:0] left_got, logic signed [8:0] right_got);
            stereo_mix_t want;
            if (expected_mix.size() == 0) begin
                $display("%0t: result with no tick pending, left_sum %0d right_sum %0d",
                         $time, left_got, right_got);
                errors++;
                return;
            end
            want = expected_mix.pop_front();
            checked++;
            if (left_got !== want.left) begin
                $display("%0t: left_sum expected %0d got %0d", $time, want.left, left_got);
                errors++;
            end
            if (right_got !== want.right) begin
                $display("%0t: right_sum expected %0d got %0d", $time, want.right, right_got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_mix.size();
        endfunction

        function int final_errors();
            if (expected_mix.size() != 0) begin
                $display("%0t: %0d tick results never arrived", $time, expected_mix.size());
                errors++;
            end
            return errors;
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_req_type;
    logic [1:0]        i_voice;
    logic [15:0]       i_mem_addr;
    logic signed [7:0] i_mem_data;
    logic [15:0]       i_sample_len;
    logic [15:0]       i_loop_len;
    logic [15:0]       i_start_offset;
    logic [15:0]       i_period;
    logic [6:0]        i_volume;
    logic              o_out_valid;
    logic              i_out_ready;
    logic signed [8:0] o_left_sum;
    logic signed [8:0] o_right_sum;

    sample_player_scoreboard sb;
    int  n_sent;
    int  idle_cycles;
    int  stall_left;
    bit  tx_calm;
    bit  rx_calm;

    four_voice_sample_player_pwm_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_voice        (i_voice),
        .i_mem_addr     (i_mem_addr),
        .i_mem_data     (i_mem_data),
        .i_sample_len   (i_sample_len),
        .i_loop_len     (i_loop_len),
        .i_start_offset (i_start_offset),
        .i_period       (i_period),
        .i_volume       (i_volume),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_left_sum     (o_left_sum),
        .o_right_sum    (o_right_sum)
    );

    always #6 i_clk = ~i_clk;

    // Result side: random stalls, with calm stretches where ready stays high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_left_sum, o_right_sum);
                if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, 9);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("tb_four_voice_sample_player_pwm_core NOT OK");
        $finish;
    end

    function automatic req_item_t make_item(t_req kind);
        req_item_t it;
        it.kind     = kind;
        it.voice    = 2'($urandom);
        it.addr     = 16'($urandom);
        it.data     = 8'($urandom);
        it.len      = 16'($urandom);
        it.loop_len = 16'($urandom);
        it.offs     = 16'($urandom);
        it.period   = 16'($urandom);
        it.volume   = 7'($urandom);
        return it;
    endfunction

    // Half the addresses fall in a few small regions so written bytes get replayed.
    function automatic logic [15:0] pick_addr();
        logic [15:0] hot;
        case ($urandom_range(0, 5))
            0: hot = 16'h0000;
            1: hot = 16'hFFF0;
            2: hot = 16'h7FF8;
            default: return 16'($urandom);
        endcase
        return hot + 16'($urandom_range(0, 15));
    endfunction

    task automatic send_item(req_item_t it);
        int gap;
        if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= it.kind;
        i_voice        <= it.voice;
        i_mem_addr     <= it.addr;
        i_mem_data     <= it.data;
        i_sample_len   <= it.len;
        i_loop_len     <= it.loop_len;
        i_start_offset <= it.offs;
        i_period       <= it.period;
        i_volume       <= it.volume;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sb.note_input(it);
        n_sent++;
    endtask

    task automatic write_byte(logic [15:0] addr, logic [7:0] data);
        req_item_t it;
        it = make_item(REQ_WRITE);
        it.addr = addr;
        it.data = data;
        send_item(it);
    endtask

    task automatic trigger_voice(logic [1:0] v, logic [15:0] addr, logic [15:0] ln,
                                 logic [15:0] lpn, logic [15:0] offs);
        req_item_t it;
        it = make_item(REQ_TRIGGER);
        it.voice    = v;
        it.addr     = addr;
        it.len      = ln;
        it.loop_len = lpn;
        it.offs     = offs;
        send_item(it);
    endtask

    task automatic set_voice(logic [1:0] v, logic [15:0] period, logic [6:0] volume);
        req_item_t it;
        it = make_item(REQ_SET);
        it.voice  = v;
        it.period = period;
        it.volume = volume;
        send_item(it);
    endtask

    // Every byte a tick is about to fetch gets written first.
    task automatic tick_once();
        logic [15:0] addr;
        while (sb.unwritten_fetch(addr)) write_byte(addr, 8'($urandom));
        send_item(make_item(REQ_TICK));
    endtask

    task automatic drain_pause();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] ln;
        int r;
        sb = new();
        n_sent      = 0;
        tx_calm     = 0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_req_type     <= REQ_TICK;
        i_voice        <= '0;
        i_mem_addr     <= '0;
        i_mem_data     <= '0;
        i_sample_len   <= '0;
        i_loop_len     <= '0;
        i_start_offset <= '0;
        i_period       <= '0;
        i_volume       <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: idle tick, sets on idle voices, clamping and address wrap.
        tick_once();
        set_voice(0, 16'd0, 7'd64);
        set_voice(1, 16'hFFFF, 7'd127);
        set_voice(2, 16'd2, 7'd0);
        set_voice(3, 16'd1, 7'd65);
        write_byte(16'hFFFF, 8'h80);
        write_byte(16'h0000, 8'h7F);
        trigger_voice(0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        tick_once();
        trigger_voice(1, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        trigger_voice(2, 16'h8000, 16'd4, 16'd9, 16'd2);
        trigger_voice(3, 16'hFFFE, 16'd3, 16'd1, 16'd0);
        repeat (5) tick_once();
        // A retrigger keeps the divider, PWM phase and held byte.
        trigger_voice(2, 16'h8002, 16'd4, 16'd4, 16'd1);
        repeat (2) tick_once();
        drain_pause();

        while (n_sent < TARGET_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                tick_once();
            end else if (r < 72) begin
                case ($urandom_range(0, 19))
                    0: ln = 16'd0;
                    1: ln = 16'hFFFF;
                    2: ln = 16'($urandom);
                    default: ln = 16'($urandom_range(1, 16));
                endcase
                trigger_voice(2'($urandom), pick_addr(), ln,
                              ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 17)),
                              ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 20)));
            end else if (r < 85) begin
                case ($urandom_range(0, 9))
                    0: ln = 16'd0;
                    1: ln = 16'hFFFF;
                    2: ln = 16'($urandom);
                    default: ln = 16'($urandom_range(1, 4));
                endcase
                case ($urandom_range(0, 7))
                    0: set_voice(2'($urandom), ln, 7'd0);
                    1: set_voice(2'($urandom), ln, 7'd64);
                    2: set_voice(2'($urandom), ln, 7'd127);
                    3: set_voice(2'($urandom), ln, 7'($urandom_range(65, 127)));
                    default: set_voice(2'($urandom), ln, 7'($urandom_range(0, 64)));
                endcase
            end else begin
                write_byte(pick_addr(), 8'($urandom));
            end
            if (n_sent == TARGET_ITEMS / 2 || $urandom_range(0, 199) == 0) drain_pause();
        end

        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d items: %0d ticks, %0d writes, %0d triggers, %0d sets",
                 n_sent, sb.kind_count[REQ_TICK], sb.kind_count[REQ_WRITE],
                 sb.kind_count[REQ_TRIGGER], sb.kind_count[REQ_SET]);
        $display("compared %0d stereo results against the prediction", sb.checked);
        if (sb.final_errors() == 0) begin
            $display("tb_four_voice_sample_player_pwm_core OK");
        end else begin
            $display("tb_four_voice_sample_player_pwm_core NOT OK");
        end
        $finish;
    end

endmodule
